FILE: sv/rc4ks_pkg.sv
`timescale 1ns / 1ps
// rc4ks_pkg: types and constants shared by the keystream cipher unit
// no dependencies; imported by the memory, sequencer, output stage and top level
package rc4ks_pkg;

    localparam int BYTE_W  = 8;
    localparam int DEPTH   = 256;
    localparam int ADDR_W  = $clog2(DEPTH);

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // function code of an input item
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_CIPHER = 1'b1;

    // one port command of the permutation memory
    typedef struct packed {
        logic  we;
        logic  re;
        addr_t addr;
        byte_t wdata;
    } mem_req_t;

    // result offered by the sequencer to the output stage
    typedef struct packed {
        logic  valid;
        byte_t data;
        logic  last;
    } res_t;

endpackage

FILE: sv/rc4ks_perm_mem.sv
`timescale 1ns / 1ps
// rc4ks_perm_mem: 256 x 8 dual-port permutation memory, registered read data
// depends on rc4ks_pkg
module rc4ks_perm_mem (
    input  logic                clk,
    input  rc4ks_pkg::mem_req_t req_a,
    input  rc4ks_pkg::mem_req_t req_b,
    output rc4ks_pkg::byte_t    rd_a,
    output rc4ks_pkg::byte_t    rd_b
);
    import rc4ks_pkg::*;

    byte_t mem [DEPTH];
    byte_t rd_a_reg;
    byte_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (req_b.we)
        begin
            mem[req_b.addr] <= req_b.wdata;
        end
        if (req_a.we)
        begin
            mem[req_a.addr] <= req_a.wdata;
        end
        if (req_a.re)
        begin
            rd_a_reg <= mem[req_a.addr];
        end
        if (req_b.re)
        begin
            rd_b_reg <= mem[req_b.addr];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

FILE: sv/rc4ks_seq.sv
`timescale 1ns / 1ps
// rc4ks_seq: item sequencer, indices, swap with deferred write-back and keystream forwarding
// depends on rc4ks_pkg; drives both ports of rc4ks_perm_mem
module rc4ks_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  rc4ks_pkg::byte_t    index,
    input  rc4ks_pkg::byte_t    value,
    input  rc4ks_pkg::byte_t    data_in,
    input  logic                last_in,
    output rc4ks_pkg::mem_req_t req_a,
    output rc4ks_pkg::mem_req_t req_b,
    input  rc4ks_pkg::byte_t    rd_a,
    input  rc4ks_pkg::byte_t    rd_b,
    output rc4ks_pkg::res_t     res,
    input  logic                res_take
);
    import rc4ks_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_LOAD    = 5'b00010,
        ST_FETCH_I = 5'b00100,
        ST_FETCH_J = 5'b01000,
        ST_SWAP    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    addr_t i_reg, i_next;
    addr_t j_reg, j_next;
    byte_t a_reg, a_next;

    logic  pend_valid_reg, pend_valid_next;
    addr_t pend_addr_reg, pend_addr_next;
    byte_t pend_data_reg, pend_data_next;

    logic  res_pend_reg, res_pend_next;
    logic  ks_fwd_en_reg, ks_fwd_en_next;
    byte_t ks_fwd_reg, ks_fwd_next;
    byte_t res_din_reg, res_din_next;
    logic  res_last_reg, res_last_next;

    addr_t index_reg, index_next;
    byte_t value_reg, value_next;
    byte_t din_reg, din_next;
    logic  last_reg, last_next;

    logic  ready;
    logic  in_fire;
    logic  j_go;
    addr_t j_calc;
    addr_t t_addr;
    logic  pend_hit;

    assign ready    = (state_reg == ST_IDLE) || (state_reg == ST_LOAD) || (state_reg == ST_SWAP);
    assign in_stall = !ready;
    assign in_fire  = in_valid && ready;
    assign j_go     = !res_pend_reg;
    assign j_calc   = j_reg + rd_a;
    assign t_addr   = a_reg + rd_a;
    assign pend_hit = (state_reg == ST_LOAD) && (index_reg == pend_addr_reg);

    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        a_next          = a_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_data_next  = pend_data_reg;
        res_pend_next   = res_pend_reg && !res_take;
        ks_fwd_en_next  = ks_fwd_en_reg;
        ks_fwd_next     = ks_fwd_reg;
        res_din_next    = res_din_reg;
        res_last_next   = res_last_reg;
        index_next      = index_reg;
        value_next      = value_reg;
        din_next        = din_reg;
        last_next       = last_reg;

        req_a = '0;
        req_b = '0;

        // deferred write of the first swap entry
        if (pend_valid_reg && !pend_hit)
        begin
            req_b.we    = 1'b1;
            req_b.addr  = pend_addr_reg;
            req_b.wdata = pend_data_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_LOAD:
            begin
                req_a.we    = 1'b1;
                req_a.addr  = index_reg;
                req_a.wdata = value_reg;
                i_next      = '0;
                j_next      = '0;
            end
            ST_FETCH_I:
            begin
                req_a.re   = 1'b1;
                req_a.addr = i_reg + addr_t'(1);
                i_next     = i_reg + addr_t'(1);
                state_next = ST_FETCH_J;
            end
            ST_FETCH_J:
            begin
                if (j_go)
                begin
                    req_a.re   = 1'b1;
                    req_a.addr = j_calc;
                    j_next     = j_calc;
                    a_next     = rd_a;
                    state_next = ST_SWAP;
                end
            end
            ST_SWAP:
            begin
                // rd_a holds the entry at j, a_reg the entry at i
                req_a.we        = 1'b1;
                req_a.addr      = j_reg;
                req_a.wdata     = a_reg;
                req_b           = '0;
                req_b.re        = 1'b1;
                req_b.addr      = t_addr;
                pend_valid_next = 1'b1;
                pend_addr_next  = i_reg;
                pend_data_next  = rd_a;
                res_pend_next   = 1'b1;
                ks_fwd_en_next  = (t_addr == i_reg) || (t_addr == j_reg);
                ks_fwd_next     = (t_addr == i_reg) ? rd_a : a_reg;
                res_din_next    = din_reg;
                res_last_next   = last_reg;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ready)
        begin
            if (in_fire)
            begin
                state_next = (func == FUNC_CIPHER) ? ST_FETCH_I : ST_LOAD;
                index_next = index;
                value_next = value;
                din_next   = data_in;
                last_next  = last_in;
            end
            else
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            pend_valid_reg <= 1'b0;
            res_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            pend_valid_reg <= pend_valid_next;
            res_pend_reg   <= res_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        pend_addr_reg <= pend_addr_next;
        pend_data_reg <= pend_data_next;
        ks_fwd_en_reg <= ks_fwd_en_next;
        ks_fwd_reg    <= ks_fwd_next;
        res_din_reg   <= res_din_next;
        res_last_reg  <= res_last_next;
        index_reg     <= index_next;
        value_reg     <= value_next;
        din_reg       <= din_next;
        last_reg      <= last_next;
    end

    always_comb
    begin
        res.valid = res_pend_reg;
        res.data  = res_din_reg ^ (ks_fwd_en_reg ? ks_fwd_reg : rd_b);
        res.last  = res_last_reg;
    end

endmodule

FILE: sv/rc4ks_out_stage.sv
`timescale 1ns / 1ps
// rc4ks_out_stage: output register between the sequencer and the result channel
// depends on rc4ks_pkg
module rc4ks_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  rc4ks_pkg::res_t  res,
    output logic             res_take,
    output logic             out_valid,
    input  logic             out_stall,
    output rc4ks_pkg::byte_t data_out,
    output logic             last_out
);
    import rc4ks_pkg::*;

    logic  out_valid_reg;
    byte_t data_reg;
    logic  last_reg;

    assign res_take = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res.valid)
        begin
            data_reg <= res.data;
            last_reg <= res.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_reg;
    assign last_out  = last_reg;

endmodule

FILE: sv/rc4_keystream_cipher_unit.sv
`timescale 1ns / 1ps
// rc4_keystream_cipher_unit: top level of the keystream generator and byte cipher
// depends on rc4ks_pkg, rc4ks_perm_mem, rc4ks_seq, rc4ks_out_stage
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  input   | in_valid / in_stall | func, index, value, data_in, last_in
//  result  | out_valid/out_stall | data_out, last_out
//
// a cipher item does a read of S[i], a read of S[j], then the swap write with
// the keystream read, a chain of three dependent memory reads
// a load item gives no result
// reset clears i, j and all valid flags; the permutation memory is not cleared
// a finished result waits in the output register while the next item is taken; one
// more waits in the memory read register, later cipher items hold at the j read
module rc4_keystream_cipher_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  rc4ks_pkg::byte_t    index,
    input  rc4ks_pkg::byte_t    value,
    input  rc4ks_pkg::byte_t    data_in,
    input  logic                last_in,
    output logic                out_valid,
    input  logic                out_stall,
    output rc4ks_pkg::byte_t    data_out,
    output logic                last_out
);
    import rc4ks_pkg::*;

    mem_req_t req_a;
    mem_req_t req_b;
    byte_t    rd_a;
    byte_t    rd_b;
    res_t     res;
    logic     res_take;

    rc4ks_perm_mem u_mem (
        .clk   (clk),
        .req_a (req_a),
        .req_b (req_b),
        .rd_a  (rd_a),
        .rd_b  (rd_b)
    );

    rc4ks_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .index    (index),
        .value    (value),
        .data_in  (data_in),
        .last_in  (last_in),
        .req_a    (req_a),
        .req_b    (req_b),
        .rd_a     (rd_a),
        .rd_b     (rd_b),
        .res      (res),
        .res_take (res_take)
    );

    rc4ks_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_take  (res_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .last_out  (last_out)
    );

endmodule

FILE: tb/tb_rc4_keystream_cipher_unit.sv
`timescale 1ns / 1ps
// tb_rc4_keystream_cipher_unit: self-checking testbench of the keystream cipher unit
// depends on rc4ks_pkg and rc4_keystream_cipher_unit; a tracker class predicts each byte
module tb_rc4_keystream_cipher_unit;
    import rc4ks_pkg::*;

    localparam int RAND_ITEMS  = 1000;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 20;

    class keystream_tracker;
        byte_t perm [DEPTH];
        byte_t idx_i;
        byte_t idx_j;
        byte_t expected_bytes [$];
        logic  expected_last [$];
        int    errors;
        int    bytes_checked;
        int    loads;
        int    equal_swaps;

        function new();
            idx_i = '0;
            idx_j = '0;
            errors = 0;
            bytes_checked = 0;
            loads = 0;
            equal_swaps = 0;
        endfunction

        function void note_item(logic f, byte_t pos, byte_t val, byte_t din, logic mark);
            byte_t a;
            byte_t b;
            if (f == FUNC_LOAD)
            begin
                perm[pos] = val;
                idx_i = '0;
                idx_j = '0;
                loads++;
            end
            else
            begin
                idx_i = idx_i + 8'd1;
                idx_j = idx_j + perm[idx_i];
                a = perm[idx_i];
                b = perm[idx_j];
                if (idx_i == idx_j)
                    equal_swaps++;
                perm[idx_i] = b;
                perm[idx_j] = a;
                expected_bytes.push_back(din ^ perm[byte_t'(a + b)]);
                expected_last.push_back(mark);
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(byte_t d, logic l);
            byte_t ed;
            logic  el;
            if (expected_bytes.size() == 0)
            begin
                report_mismatch($sformatf("result %02h with nothing expected", d));
                return;
            end
            ed = expected_bytes.pop_front();
            el = expected_last.pop_front();
            bytes_checked++;
            if (d !== ed)
                report_mismatch($sformatf("data_out %02h, expected %02h", d, ed));
            if (l !== el)
                report_mismatch($sformatf("last_out %b, expected %b", l, el));
        endtask
    endclass

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_stall;
    logic  func      = FUNC_LOAD;
    byte_t index     = '0;
    byte_t value     = '0;
    byte_t data_in   = '0;
    logic  last_in   = 1'b0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    byte_t data_out;
    logic  last_out;

    keystream_tracker tracker = new();
    int idle_pct     = 0;
    int stall_pct    = 0;
    int items_sent   = 0;
    int cycles       = 0;

    rc4_keystream_cipher_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .index     (index),
        .value     (value),
        .data_in   (data_in),
        .last_in   (last_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .last_out  (last_out)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(data_out, last_out);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(logic f, byte_t pos, byte_t val, byte_t din, logic mark);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        index    <= pos;
        value    <= val;
        data_in  <= din;
        last_in  <= mark;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        tracker.note_item(f, pos, val, din, mark);
        items_sent++;
    endtask

    task automatic load_key_schedule();
        byte_t s [DEPTH];
        byte_t key [16];
        int    order [DEPTH];
        int    klen;
        int    r;
        int    tmp;
        byte_t jk;
        byte_t t;
        klen = $urandom_range(16, 1);
        for (int k = 0; k < 16; k++)
            key[k] = byte_t'($urandom);
        for (int k = 0; k < DEPTH; k++)
        begin
            s[k] = byte_t'(k);
            order[k] = k;
        end
        jk = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            jk = jk + s[k] + key[k % klen];
            t = s[k];
            s[k] = s[jk];
            s[jk] = t;
        end
        // entries go in shuffled order
        for (int k = DEPTH - 1; k > 0; k--)
        begin
            r = $urandom_range(k);
            tmp = order[k];
            order[k] = order[r];
            order[r] = tmp;
        end
        for (int k = 0; k < DEPTH; k++)
            send_item(FUNC_LOAD, byte_t'(order[k]), s[order[k]], byte_t'($urandom),
                      1'($urandom_range(1)));
    endtask

    task automatic send_message(int len);
        for (int k = 0; k < len; k++)
            send_item(FUNC_CIPHER, byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
                      (k == len - 1) ? 1'b1 : ($urandom_range(9) == 0));
    endtask

    initial
    begin
        int rand_start;
        int sel;
        int phase;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // whole table first, so every later read hits a written entry
        load_key_schedule();
        send_item(FUNC_CIPHER, 8'hFF, 8'h00, 8'h00, 1'b0);
        send_item(FUNC_CIPHER, 8'h00, 8'hFF, 8'hFF, 1'b1);
        send_item(FUNC_CIPHER, 8'hA5, 8'h5A, 8'h80, 1'b0);
        // ignored fields at their extremes on a load
        send_item(FUNC_LOAD, 8'd0, 8'h00, 8'hFF, 1'b1);
        send_item(FUNC_LOAD, 8'hFF, 8'hFF, 8'h00, 1'b0);
        // S[1] = 1 forces i == j on the next byte
        send_item(FUNC_LOAD, 8'd1, 8'd1, 8'h55, 1'b1);
        send_item(FUNC_CIPHER, 8'h00, 8'h00, 8'h3C, 1'b1);
        send_message(4);
        load_key_schedule();
        send_message(6);

        rand_start = items_sent;
        while (items_sent - rand_start < RAND_ITEMS)
        begin
            phase = (items_sent - rand_start) * 4 / RAND_ITEMS;
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 56; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            sel = $urandom_range(99);
            if (sel < 1)
                load_key_schedule();
            else if (sel < 10)
                repeat ($urandom_range(3, 1))
                    send_item(FUNC_LOAD, byte_t'($urandom), byte_t'($urandom),
                              byte_t'($urandom), 1'($urandom_range(1)));
            else if (sel < 15)
                send_message($urandom_range(64, 17));
            else
                send_message($urandom_range(16, 1));
        end
        in_valid <= 1'b0;

        while (tracker.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d items sent: %0d table loads, %0d bytes ciphered and checked",
                 items_sent, tracker.loads, tracker.bytes_checked);
        $display("%0d swaps with equal indices, %0d mismatches",
                 tracker.equal_swaps, tracker.errors);
        if (tracker.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
sv/rc4ks_pkg.sv
sv/rc4ks_perm_mem.sv
sv/rc4ks_seq.sv
sv/rc4ks_out_stage.sv
sv/rc4_keystream_cipher_unit.sv
tb/tb_rc4_keystream_cipher_unit.sv
